@@ rtl/slid_pkg.sv @@
// Shared types, codes and sizes for the sorted list insert/delete unit.
`timescale 1ns / 1ps

package slid_pkg;

  // Sizes
  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;
  localparam int DEF_CAPACITY = 16;
  localparam int QUEUE_DEPTH  = 2;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  // Command kinds carried through the queue
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd5;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } out_beat_t;

  // Classified command
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Push request from the front end into the queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

endpackage

@@ rtl/slid_front.sv @@
// Front end: accepts input beats and classifies them into commands.
`timescale 1ns / 1ps

module slid_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  slid_pkg::in_beat_t  in_data,
  input  logic                q_full,
  output slid_pkg::q_push_t   push
);

  logic       known;
  logic [1:0] kind;

  // Decode the operation; the unused code is accepted and dropped
  always_comb begin
    known = 1'b1;
    kind  = slid_pkg::CMD_INSERT;
    unique case (in_data.operation)
      slid_pkg::OP_INSERT: kind = slid_pkg::CMD_INSERT;
      slid_pkg::OP_DELETE: kind = slid_pkg::CMD_DELETE;
      slid_pkg::OP_DUMP:   kind = slid_pkg::CMD_DUMP;
      default:             known = 1'b0;
    endcase
  end

  // Take a beat whenever the queue has room
  assign in_ready       = !q_full;
  assign push.valid     = in_valid && in_ready && known;
  assign push.cmd.kind  = kind;
  assign push.cmd.value = in_data.value;

endmodule

@@ rtl/slid_cmd_queue.sv @@
// Short command queue between the front end and the list engine.
`timescale 1ns / 1ps

module slid_cmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  slid_pkg::q_push_t push,
  output logic              q_full,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output slid_pkg::cmd_t    cmd
);

  localparam int PTR_W  = (slid_pkg::QUEUE_DEPTH > 1) ? $clog2(slid_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(slid_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(slid_pkg::QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(slid_pkg::QUEUE_DEPTH);

  slid_pkg::cmd_t    slot_r [slid_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_pop;

  assign q_full    = (fill_r == FULL_CNT);
  assign cmd_valid = (fill_r != '0);
  assign cmd       = slot_r[rd_ptr_r];
  assign do_pop    = cmd_valid && cmd_ready;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push.valid && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (!push.valid && do_pop) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

@@ rtl/slid_back.sv @@
// List engine: row of sorted cells, insert/delete shifts and dump rotation.
`timescale 1ns / 1ps

module slid_back #(
  parameter int CAPACITY = slid_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  slid_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output slid_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic signed [slid_pkg::DATA_W-1:0] cell_r  [CAPACITY];
  logic signed [slid_pkg::DATA_W-1:0] ins_val [CAPACITY];
  logic signed [slid_pkg::DATA_W-1:0] del_val [CAPACITY];
  logic signed [slid_pkg::DATA_W-1:0] rot_val [CAPACITY];

  logic [CAPACITY-1:0] keep_ins, keep_del, match;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                state_r, state_nxt;
  slid_pkg::out_beat_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free, pop, full, empty, found, dump_last;
  logic                upd_ins, upd_del, upd_rot;
  logic [CW-1:0]       top_idx;

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;
  assign pop       = cmd_valid && cmd_ready;
  assign full      = (count_r == CAP_CNT);
  assign empty     = (count_r == '0);
  assign found     = |match;
  assign top_idx   = count_r - CW'(1);
  assign dump_last = (idx_r == top_idx);

  // Per-cell compare and candidate next values
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occupied, lt, eq;
    logic signed [slid_pkg::DATA_W-1:0] prev_v, next_v;

    assign occupied    = (CW'(i) < count_r);
    assign lt          = (cell_r[i] < cmd.value);
    assign eq          = (cell_r[i] == cmd.value);
    assign keep_ins[i] = occupied && (lt || eq);
    assign keep_del[i] = occupied && lt;
    assign match[i]    = occupied && eq;

    if (i == 0) begin : g_first
      assign prev_v = cmd.value;
    end else begin : g_mid
      assign prev_v = keep_ins[i-1] ? cmd.value : cell_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign next_v = cell_r[i];
    end else begin : g_below
      assign next_v = cell_r[i+1];
    end

    assign ins_val[i] = keep_ins[i] ? cell_r[i] : prev_v;
    assign del_val[i] = keep_del[i] ? cell_r[i] : next_v;
    assign rot_val[i] = (CW'(i) == top_idx) ? cell_r[0] : next_v;
  end

  // Sequence commands and dump streaming
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    upd_ins       = 1'b0;
    upd_del       = 1'b0;
    upd_rot       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          out_nxt.item = '0;
          out_nxt.last = 1'b1;
          unique case (cmd.kind)
            slid_pkg::CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.status = slid_pkg::ST_FULL;
              end else begin
                out_nxt.status = slid_pkg::ST_OK;
                upd_ins        = 1'b1;
                count_nxt      = count_r + CW'(1);
              end
            end
            slid_pkg::CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_nxt.status = slid_pkg::ST_EMPTY;
              end else if (!found) begin
                out_nxt.status = slid_pkg::ST_NOT_FOUND;
              end else begin
                out_nxt.status = slid_pkg::ST_OK;
                upd_del        = 1'b1;
                count_nxt      = top_idx;
              end
            end
            slid_pkg::CMD_DUMP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = slid_pkg::ST_DUMP_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                idx_nxt   = '0;
              end
            end
            default: begin
              out_nxt = out_r;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = slid_pkg::ST_ENTRY;
          out_nxt.item   = cell_r[0];
          out_nxt.last   = dump_last;
          upd_rot        = 1'b1;
          idx_nxt        = idx_r + CW'(1);
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Update the cell row and the result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < CAPACITY; i++) begin
      if (upd_ins) begin
        cell_r[i] <= ins_val[i];
      end else if (upd_del) begin
        cell_r[i] <= del_val[i];
      end else if (upd_rot) begin
        cell_r[i] <= rot_val[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r >= CW'(2)) |-> (cell_r[0] <= cell_r[1]))
    else $error("list head out of order");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.kind == slid_pkg::CMD_INSERT && full) |=> (count_r == $past(count_r)))
    else $error("refused insert changed the count");

  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && slot_free && dump_last) |=> (state_r == S_IDLE && out_r.last))
    else $error("dump did not end on its last entry");
`endif

endmodule

@@ rtl/sorted_list_insert_delete_unit.sv @@
// Top level of the sorted list insert/delete unit.
// Usage: the input channel (in_valid/in_ready/in_data) takes one beat per
// command: insert, delete or dump of a signed 32-bit value list kept in
// ascending order, up to CAPACITY entries. The result channel
// (out_valid/out_ready/out_data) returns one status beat per insert or
// delete, and one beat per stored entry for a dump (a single beat when
// the list is empty); the final beat of every command has last set.
// The unused operation code is taken and dropped with no result.
// A status beat passes through the command queue and then the result
// register after its command is taken.
// Throughput: insert and delete run at one per cycle through the cell row
// (all cells compare and shift at once) while the receiver takes results;
// a dump holds the engine while it rotates the cell row past the head
// cell. A two-beat command queue decouples intake from the engine.
// Reset empties the list and the queue; no clearing pass is needed.
// When the receiver stalls, the result register holds its beat, the
// engine waits, and intake continues until the queue fills.
`timescale 1ns / 1ps

module sorted_list_insert_delete_unit #(
  parameter int CAPACITY = slid_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slid_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slid_pkg::out_beat_t out_data
);

  slid_pkg::q_push_t push;
  slid_pkg::cmd_t    cmd;
  logic              q_full;
  logic              cmd_valid;
  logic              cmd_ready;

  slid_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  slid_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_full    (q_full),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  slid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/sorted_list_insert_delete_unit_tb.sv @@
// Self-checking testbench for the sorted list insert/delete unit.
`timescale 1ns / 1ps

module sorted_list_insert_delete_unit_tb;
  import slid_pkg::*;

  localparam int              LIST_CAP     = DEF_CAPACITY;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              RANDOM_ITEMS = 250;
  localparam int              TAIL_CYCLES  = 40;
  localparam int              CYCLE_LIMIT  = 400000;

  // Random episode kinds
  localparam int EP_PACK  = 0;
  localparam int EP_FILL  = 1;
  localparam int EP_DRAIN = 2;
  localparam int EP_MIXED = 3;

  // Receiver stall modes
  localparam logic [1:0] RDY_ALWAYS = 2'd0;
  localparam logic [1:0] RDY_COIN   = 2'd1;
  localparam logic [1:0] RDY_SPARSE = 2'd2;
  localparam logic [1:0] RDY_MOSTLY = 2'd3;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic [STATUS_W-1:0]      want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Predictor state and the results still owed by the block
  logic signed [DATA_W-1:0] stored_values[$];
  out_beat_t                step_results[$];
  out_beat_t                owed_results[$];
  stim_row_t                directed_rows[$];

  int          fail_count  = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  logic [1:0]  ready_mode  = RDY_ALWAYS;
  logic [5:0]  ready_tick  = '0;

  sorted_list_insert_delete_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sorted_list_insert_delete_unit");
      $finish;
    end
  end

  // Receiver: switch stall pattern whenever the tick counter wraps
  always @(posedge clk) begin
    ready_tick <= ready_tick + 6'd1;
    if (ready_tick == '0) begin
      ready_mode <= 2'($urandom_range(0, 3));
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= (ready_tick[1:0] == 2'd0);
        default:    out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each result beat with the oldest owed result
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result beat: status %0d item %0d last %0b",
               out_data.status, out_data.item, out_data.last);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.item !== want.item) begin
          $error("item: expected %0d, got %0d", want.item, out_data.item);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  function automatic out_beat_t make_result(logic [STATUS_W-1:0] status,
                                            logic signed [DATA_W-1:0] item,
                                            logic last);
    out_beat_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    return r;
  endfunction

  // Work out the results of one command and update the list copy
  task automatic predict_list_op(input in_beat_t cmd);
    int pos;
    step_results.delete();
    case (cmd.operation)
      OP_INSERT: begin
        if (stored_values.size() >= LIST_CAP) begin
          step_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < stored_values.size() &&
                 $signed(stored_values[pos]) <= $signed(cmd.value)) pos++;
          stored_values.insert(pos, cmd.value);
          step_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      OP_DELETE: begin
        if (stored_values.size() == 0) begin
          step_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < stored_values.size() && stored_values[pos] != cmd.value) pos++;
          if (pos == stored_values.size()) begin
            step_results.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
          end else begin
            stored_values.delete(pos);
            step_results.push_back(make_result(ST_OK, '0, 1'b1));
          end
        end
      end
      OP_DUMP: begin
        if (stored_values.size() == 0) begin
          step_results.push_back(make_result(ST_DUMP_EMPTY, '0, 1'b1));
        end else begin
          foreach (stored_values[i]) begin
            step_results.push_back(make_result(ST_ENTRY, stored_values[i],
                                               i == stored_values.size() - 1));
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat, hold it until taken, then record what it owes
  task automatic send_command(input in_beat_t cmd, input bit typed,
                              input logic [STATUS_W-1:0] want);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    predict_list_op(cmd);
    if (typed) begin
      owed_results.push_back(make_result(want, '0, 1'b1));
    end else begin
      foreach (step_results[i]) owed_results.push_back(step_results[i]);
    end
  endtask

  // Sender pacing: bursts of random length with random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 8)) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_stored();
    if (stored_values.size() == 0) return pick_value();
    return stored_values[$urandom_range(0, stored_values.size() - 1)];
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                  bit typed, logic [STATUS_W-1:0] want);
    stim_row_t row;
    row.op    = op;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  initial begin : stimulus
    in_beat_t cmd;
    int       issued;
    int       ep_kind;
    int       ep_left;
    int       roll;
    bit       paused;

    // Directed table: empty list, only element, extremes, duplicates, absent value
    add_row(OP_DUMP,   '0,             1'b1, ST_DUMP_EMPTY);
    add_row(OP_DELETE, 32'sd5,         1'b1, ST_EMPTY);
    add_row(OP_UNUSED, 32'sh7FFF_FFFF, 1'b0, ST_OK);
    add_row(OP_INSERT, 32'sd42,        1'b1, ST_OK);
    add_row(OP_DELETE, 32'sd42,        1'b1, ST_OK);
    add_row(OP_DUMP,   32'sh5555_AAAA, 1'b1, ST_DUMP_EMPTY);
    add_row(OP_INSERT, 32'sh7FFF_FFFF, 1'b1, ST_OK);
    add_row(OP_INSERT, 32'sh8000_0000, 1'b1, ST_OK);
    add_row(OP_INSERT, '0,             1'b1, ST_OK);
    add_row(OP_INSERT, '1,             1'b1, ST_OK);
    add_row(OP_INSERT, '0,             1'b1, ST_OK);
    add_row(OP_INSERT, 32'sd1,         1'b0, ST_OK);
    add_row(OP_DUMP,   '0,             1'b0, ST_OK);
    add_row(OP_DELETE, '0,             1'b1, ST_OK);
    add_row(OP_DELETE, 32'sd12345,     1'b1, ST_NOT_FOUND);
    add_row(OP_DELETE, 32'sh8000_0000, 1'b1, ST_OK);
    add_row(OP_DUMP,   '1,             1'b0, ST_OK);
    add_row(OP_DELETE, 32'sh7FFF_FFFF, 1'b1, ST_OK);
    add_row(OP_DELETE, '1,             1'b1, ST_OK);
    add_row(OP_DELETE, 32'sd1,         1'b1, ST_OK);
    add_row(OP_DELETE, '0,             1'b1, ST_OK);
    add_row(OP_DUMP,   '0,             1'b1, ST_DUMP_EMPTY);

    // Hold reset, release synchronously
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      cmd.operation = directed_rows[i].op;
      cmd.value     = directed_rows[i].value;
      send_command(cmd, directed_rows[i].typed, directed_rows[i].want);
      pace_sender();
    end
    drain_results();

    // Random part: episodes that pack, fill, drain or mix the list
    issued  = 0;
    paused  = 1'b0;
    ep_kind = EP_PACK;
    ep_left = LIST_CAP + 4;
    while (issued < RANDOM_ITEMS) begin
      if (ep_left == 0) begin
        ep_kind = $urandom_range(EP_FILL, EP_MIXED);
        ep_left = $urandom_range(10, 40);
      end
      ep_left--;
      roll = $urandom_range(0, 99);
      cmd.value = pick_value();
      case (ep_kind)
        EP_PACK: cmd.operation = OP_INSERT;
        EP_FILL: begin
          if (roll < 75)      cmd.operation = OP_INSERT;
          else if (roll < 85) cmd.operation = OP_DUMP;
          else if (roll < 97) cmd.operation = OP_DELETE;
          else                cmd.operation = OP_UNUSED;
          if (roll >= 85 && roll < 93) cmd.value = pick_stored();
        end
        EP_DRAIN: begin
          if (roll < 78)      cmd.operation = OP_DELETE;
          else if (roll < 90) cmd.operation = OP_DUMP;
          else if (roll < 98) cmd.operation = OP_INSERT;
          else                cmd.operation = OP_UNUSED;
          if (roll < 65) cmd.value = pick_stored();
        end
        default: begin
          if (roll < 40)      cmd.operation = OP_INSERT;
          else if (roll < 70) cmd.operation = OP_DELETE;
          else if (roll < 92) cmd.operation = OP_DUMP;
          else                cmd.operation = OP_UNUSED;
          if (roll >= 40 && roll < 60) cmd.value = pick_stored();
        end
      endcase
      send_command(cmd, 1'b0, ST_OK);
      if (cmd.operation != OP_UNUSED) issued++;
      if (!paused && issued >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end else begin
        pace_sender();
      end
    end

    // Wait for the last results, then watch for stray beats
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sorted_list_insert_delete_unit");
    end else begin
      $display("FAIL sorted_list_insert_delete_unit");
    end
    $finish;
  end

endmodule
